// ----- src/sdtw_pkg.sv -----
`default_nettype none
package sdtw_pkg;

    localparam int MAX_DIGITS = 6;
    localparam int CNT_W      = 3;
    localparam int BIT_W      = 4;

    localparam logic [7:0] CMD_AUTOINC = 8'h40;
    localparam logic [7:0] CMD_ADDR0   = 8'hC0;
    localparam logic [7:0] CTRL_OFF    = 8'h80;
    localparam logic [7:0] CTRL_ON     = 8'h88;

    // bit counter value that marks the ack clock after a byte
    localparam logic [BIT_W-1:0] BIT_ACK = 4'd8;

    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic REG_BRIGHTNESS = 1'b0;

    typedef enum logic [1:0] {
        SEG_START,
        SEG_BYTE,
        SEG_STOP
    } seg_t;

    typedef enum logic [1:0] {
        FRAME_CMD,
        FRAME_DATA,
        FRAME_CTRL
    } frame_t;

    typedef struct packed {
        logic       command;
        logic [7:0] digit_0;
        logic [7:0] digit_1;
        logic [7:0] digit_2;
        logic [7:0] digit_3;
        logic [7:0] digit_4;
        logic [7:0] digit_5;
        logic [3:0] digit_count;
    } item_t;

    typedef struct packed {
        logic clock_level;
        logic data_level;
        logic busy_res;
        logic update_done;
    } result_t;

endpackage
`default_nettype wire

// ----- src/sdtw_cfg.sv -----
`default_nettype none
module sdtw_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output logic      [3:0]  brightness
);

    logic [3:0] brightness_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == sdtw_pkg::REG_BRIGHTNESS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 4'd0;
        end
        else if (wr_en)
        begin
            brightness_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == sdtw_pkg::REG_BRIGHTNESS)
        begin
            prdata = {28'd0, brightness_reg};
        end
    end

    assign brightness = brightness_reg;

endmodule
`default_nettype wire

// ----- src/sdtw_seq.sv -----
`default_nettype none
module sdtw_seq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire sdtw_pkg::item_t   item,
    input  wire logic [3:0]        brightness,
    output sdtw_pkg::result_t      result_next
);

    logic                         active_reg, active_next;
    sdtw_pkg::frame_t             frame_reg, frame_next;
    sdtw_pkg::seg_t               seg_reg, seg_next;
    logic [1:0]                   ph_reg, ph_next;
    logic [sdtw_pkg::BIT_W-1:0]   bit_reg, bit_next;
    logic [sdtw_pkg::CNT_W-1:0]   byte_reg, byte_next;
    logic [sdtw_pkg::CNT_W-1:0]   bytes_reg, bytes_next;
    logic [7:0]                   ctrl_reg, ctrl_next;
    logic                         clk_pin_reg, clk_pin_next;
    logic                         data_pin_reg, data_pin_next;
    logic [7:0]                   store [sdtw_pkg::MAX_DIGITS];

    logic                         start_upd;
    logic                         done;
    logic                         last_byte;
    logic [7:0]                   cur_byte;
    logic [sdtw_pkg::CNT_W-1:0]   store_idx;
    logic [sdtw_pkg::CNT_W-1:0]   cnt_sat;

    assign start_upd = accept && (item.command == sdtw_pkg::CMD_UPDATE) && !active_reg
                       && (item.digit_count != 4'd0);
    assign cnt_sat   = (item.digit_count > 4'(sdtw_pkg::MAX_DIGITS))
                       ? sdtw_pkg::CNT_W'(sdtw_pkg::MAX_DIGITS)
                       : item.digit_count[sdtw_pkg::CNT_W-1:0];
    assign store_idx = byte_reg - sdtw_pkg::CNT_W'(1);

    always_comb
    begin
        case (frame_reg)
            sdtw_pkg::FRAME_CMD:  cur_byte = sdtw_pkg::CMD_AUTOINC;
            sdtw_pkg::FRAME_CTRL: cur_byte = ctrl_reg;
            default:              cur_byte = (byte_reg == '0) ? sdtw_pkg::CMD_ADDR0
                                                              : store[store_idx];
        endcase
        last_byte = (frame_reg == sdtw_pkg::FRAME_DATA) ? (byte_reg == bytes_reg)
                                                        : (byte_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (start_upd)
        begin
            store[0] <= item.digit_0;
            store[1] <= item.digit_1;
            store[2] <= item.digit_2;
            store[3] <= item.digit_3;
            store[4] <= item.digit_4;
            store[5] <= item.digit_5;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            frame_reg    <= sdtw_pkg::FRAME_CMD;
            seg_reg      <= sdtw_pkg::SEG_START;
            ph_reg       <= 2'd0;
            bit_reg      <= '0;
            byte_reg     <= '0;
            bytes_reg    <= '0;
            ctrl_reg     <= sdtw_pkg::CTRL_OFF;
            clk_pin_reg  <= 1'b1;
            data_pin_reg <= 1'b1;
        end
        else
        begin
            active_reg   <= active_next;
            frame_reg    <= frame_next;
            seg_reg      <= seg_next;
            ph_reg       <= ph_next;
            bit_reg      <= bit_next;
            byte_reg     <= byte_next;
            bytes_reg    <= bytes_next;
            ctrl_reg     <= ctrl_next;
            clk_pin_reg  <= clk_pin_next;
            data_pin_reg <= data_pin_next;
        end
    end

    always_comb
    begin
        active_next   = active_reg;
        frame_next    = frame_reg;
        seg_next      = seg_reg;
        ph_next       = ph_reg;
        bit_next      = bit_reg;
        byte_next     = byte_reg;
        bytes_next    = bytes_reg;
        ctrl_next     = ctrl_reg;
        clk_pin_next  = clk_pin_reg;
        data_pin_next = data_pin_reg;
        done          = 1'b0;

        if (start_upd)
        begin
            active_next = 1'b1;
            frame_next  = sdtw_pkg::FRAME_CMD;
            seg_next    = sdtw_pkg::SEG_START;
            ph_next     = 2'd0;
            bit_next    = '0;
            byte_next   = '0;
            bytes_next  = cnt_sat;
            if (brightness == 4'd0)
            begin
                ctrl_next = sdtw_pkg::CTRL_OFF;
            end
            else
            begin
                ctrl_next = sdtw_pkg::CTRL_ON | {5'd0, 3'(brightness - 4'd1)};
            end
        end
        else if (accept && (item.command == sdtw_pkg::CMD_TICK) && active_reg)
        begin
            ph_next = ph_reg + 2'd1;
            case (seg_reg)
                sdtw_pkg::SEG_START:
                begin
                    if (ph_reg == 2'd0)
                    begin
                        data_pin_next = 1'b1;
                    end
                    else
                    begin
                        data_pin_next = 1'b0;
                        seg_next      = sdtw_pkg::SEG_BYTE;
                        ph_next       = 2'd0;
                        bit_next      = '0;
                        byte_next     = '0;
                    end
                end
                sdtw_pkg::SEG_BYTE:
                begin
                    if (bit_reg != sdtw_pkg::BIT_ACK)
                    begin
                        // clock low, data bit, clock high
                        case (ph_reg)
                            2'd0:    clk_pin_next  = 1'b0;
                            2'd1:    data_pin_next = cur_byte[bit_reg[2:0]];
                            default:
                            begin
                                clk_pin_next = 1'b1;
                                ph_next      = 2'd0;
                                bit_next     = bit_reg + sdtw_pkg::BIT_W'(1);
                            end
                        endcase
                    end
                    else
                    begin
                        // ack clock, never sampled
                        case (ph_reg)
                            2'd0:    clk_pin_next  = 1'b0;
                            2'd1:    data_pin_next = 1'b1;
                            2'd2:    clk_pin_next  = 1'b1;
                            default:
                            begin
                                data_pin_next = 1'b0;
                                ph_next       = 2'd0;
                                bit_next      = '0;
                                if (last_byte)
                                begin
                                    seg_next = sdtw_pkg::SEG_STOP;
                                end
                                else
                                begin
                                    byte_next = byte_reg + sdtw_pkg::CNT_W'(1);
                                end
                            end
                        endcase
                    end
                end
                default:
                begin
                    case (ph_reg)
                        2'd0:    clk_pin_next  = 1'b0;
                        2'd1:    data_pin_next = 1'b0;
                        2'd2:    clk_pin_next  = 1'b1;
                        default:
                        begin
                            data_pin_next = 1'b1;
                            ph_next       = 2'd0;
                            seg_next      = sdtw_pkg::SEG_START;
                            byte_next     = '0;
                            case (frame_reg)
                                sdtw_pkg::FRAME_CMD:  frame_next = sdtw_pkg::FRAME_DATA;
                                sdtw_pkg::FRAME_DATA: frame_next = sdtw_pkg::FRAME_CTRL;
                                default:
                                begin
                                    frame_next  = sdtw_pkg::FRAME_CMD;
                                    active_next = 1'b0;
                                    done        = 1'b1;
                                end
                            endcase
                        end
                    endcase
                end
            endcase
        end

        result_next.clock_level = clk_pin_next;
        result_next.data_level  = data_pin_next;
        result_next.busy_res    = active_next;
        result_next.update_done = done;
    end

endmodule
`default_nettype wire

// ----- src/segment_display_two_wire_writer.sv -----
// A result is in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle while a held result is not stalled; the pin sequencer handles one write per tick.
// A full update is 102 + 28*n ticks for n segment bytes (n = 1..6).
// Reset: pins idle high, sequencer idle, brightness 0, control byte 0x80.
// The segment store has no reset; an update fills it before it is read.
`default_nettype none
module segment_display_two_wire_writer (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // item channel
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire sdtw_pkg::item_t   item,
    // result channel
    output logic                   result_valid,
    input  wire logic              result_stall,
    output sdtw_pkg::result_t      result,
    // config port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    logic               accept;
    logic [3:0]         brightness;
    sdtw_pkg::result_t  res_next;
    sdtw_pkg::result_t  result_reg;
    logic               result_valid_reg;

    // Output register: a new transaction is taken whenever the held result
    // is gone or is leaving this cycle.
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    sdtw_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .brightness (brightness)
    );

    // Pin sequencer: frame / segment / byte / bit / phase counters and pin state.
    sdtw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .brightness  (brightness),
        .result_next (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // payload holds while stalled since accept is low then
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= res_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ----- sim/segment_display_two_wire_writer_tb.sv -----
`default_nettype none
module segment_display_two_wire_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdtw_pkg::*;

    // Cycles with no transaction on any port before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Floor on effective items (update starts and ticks inside a sequence) per
    // random phase; one sequence is at least 131, so a phase runs one sequence.
    localparam int PHASE_ITEMS = 120;
    localparam logic [2:0] BRIGHT_ADDR = 3'(4 * int'(REG_BRIGHTNESS));

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    segment_display_two_wire_writer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pin sequencer shadow. Updated once per accepted item, in the order
    // the block accepts them.
    // ------------------------------------------------------------------
    logic       pin_clk_q = 1'b1;
    logic       pin_dat_q = 1'b1;
    int         write_pos = 0;          // 0 idle, else 1 + index of next pin write
    logic [7:0] seg_bytes [6];
    int         seg_count = 0;
    logic [7:0] ctrl_code = CTRL_OFF;
    logic [3:0] bright_reg = 4'd0;      // our copy of the brightness register

    int updates_started = 0;
    int sequences_done = 0;
    int results_checked = 0;
    int fail_count = 0;
    int settings_used = 0;

    function automatic int sequence_len(int n);
        return 102 + 28 * n;
    endfunction

    // Byte b of a frame: command frame and control frame carry one byte,
    // the data frame carries the address then the segment bytes.
    function automatic logic [7:0] frame_byte(frame_t fr, int b);
        if (fr == FRAME_CMD)
            return CMD_AUTOINC;
        if (fr == FRAME_CTRL)
            return ctrl_code;
        if (b == 0)
            return CMD_ADDR0;
        return seg_bytes[b - 1];
    endfunction

    // Apply pin write w (from 0) of the running sequence to the pin shadow.
    function automatic void apply_pin_write(int w);
        int     data_len;
        int     o;
        int     nbytes;
        int     r;
        frame_t fr;
        logic [7:0] bval;
        data_len = 34 + 28 * seg_count;
        if (w < 34)
        begin
            fr = FRAME_CMD;  o = w;                 nbytes = 1;
        end
        else if (w < 34 + data_len)
        begin
            fr = FRAME_DATA; o = w - 34;            nbytes = 1 + seg_count;
        end
        else
        begin
            fr = FRAME_CTRL; o = w - 34 - data_len; nbytes = 1;
        end
        // start condition
        if (o < 2)
        begin
            pin_dat_q = (o == 0);
            return;
        end
        o -= 2;
        if (o < 28 * nbytes)
        begin
            r = o % 28;
            if (r < 24)
            begin
                // bit phase: clock low, data, clock high; LSB first
                case (r % 3)
                    0: pin_clk_q = 1'b0;
                    1:
                    begin
                        bval = frame_byte(fr, o / 28);
                        pin_dat_q = bval[r / 3];
                    end
                    default: pin_clk_q = 1'b1;
                endcase
            end
            else
            begin
                // ack clock, never sampled
                case (r)
                    24: pin_clk_q = 1'b0;
                    25: pin_dat_q = 1'b1;
                    26: pin_clk_q = 1'b1;
                    default: pin_dat_q = 1'b0;
                endcase
            end
            return;
        end
        // stop condition
        case (o - 28 * nbytes)
            0: pin_clk_q = 1'b0;
            1: pin_dat_q = 1'b0;
            2: pin_clk_q = 1'b1;
            default: pin_dat_q = 1'b1;
        endcase
    endfunction

    function automatic result_t next_pin_levels(item_t it);
        result_t res;
        int      cnt;
        int      w;
        logic    done;
        done = 1'b0;
        if (it.command == CMD_UPDATE)
        begin
            cnt = int'(it.digit_count);
            // ignored while busy or with a zero count
            if (write_pos == 0 && cnt != 0)
            begin
                seg_count = (cnt > MAX_DIGITS) ? MAX_DIGITS : cnt;
                seg_bytes[0] = it.digit_0;
                seg_bytes[1] = it.digit_1;
                seg_bytes[2] = it.digit_2;
                seg_bytes[3] = it.digit_3;
                seg_bytes[4] = it.digit_4;
                seg_bytes[5] = it.digit_5;
                if (bright_reg == 4'd0)
                    ctrl_code = CTRL_OFF;
                else
                    ctrl_code = CTRL_ON | {5'd0, 3'(bright_reg - 4'd1)};
                write_pos = 1;
                updates_started++;
            end
        end
        else if (write_pos != 0)
        begin
            w = write_pos - 1;
            apply_pin_write(w);
            if (w + 1 >= sequence_len(seg_count))
            begin
                write_pos = 0;
                done = 1'b1;
                sequences_done++;
            end
            else
            begin
                write_pos++;
            end
        end
        res.clock_level = pin_clk_q;
        res.data_level  = pin_dat_q;
        res.busy_res    = (write_pos != 0);
        res.update_done = done;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Queues: items waiting for the driver, pin levels waiting for the block.
    // ------------------------------------------------------------------
    item_t   pending_items [$];
    result_t pin_levels_due [$];

    logic item_fire = 1'b0;
    logic calm = 1'b0;          // no idling on either side when set
    int   src_gap = 0;
    int   sink_gap = 0;
    int   idle_cycles = 0;

    task automatic check_field(string name, logic exp_v, logic act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0b, got %0b", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // Monitor: predict on item acceptance, check on result acceptance.
    always @(posedge clk)
    begin
        logic    res_fire;
        result_t due;
        item_fire = item_valid && !item_stall;
        res_fire  = result_valid && !result_stall;
        if (rst_n)
        begin
            // check before predicting: the front entry is always the older one
            if (res_fire)
            begin
                if (pin_levels_due.size() == 0)
                begin
                    $error("result transaction with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    due = pin_levels_due.pop_front();
                    check_field("clock_level", due.clock_level, result.clock_level);
                    check_field("data_level",  due.data_level,  result.data_level);
                    check_field("busy_res",    due.busy_res,    result.busy_res);
                    check_field("update_done", due.update_done, result.update_done);
                    results_checked++;
                end
            end
            if (item_fire)
                pin_levels_due.push_back(next_pin_levels(item));
        end
        // watchdog on transaction activity
        if (item_fire || res_fire || psel)
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", HANG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Driver: a new item (or an idle burst) only once the current one is taken.
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_fire))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                item_valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 11) == 0)
            begin
                src_gap = $urandom_range(0, 14);
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in bursts.
    always @(negedge clk)
    begin
        if (sink_gap > 0)
        begin
            sink_gap--;
            result_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            sink_gap = $urandom_range(0, 14);
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic item_t make_update(logic [3:0] cnt, logic [47:0] digits);
        item_t it;
        it.command     = CMD_UPDATE;
        {it.digit_0, it.digit_1, it.digit_2, it.digit_3, it.digit_4, it.digit_5} = digits;
        it.digit_count = cnt;
        return it;
    endfunction

    function automatic logic [47:0] random_digits();
        return {$urandom(), 16'($urandom())};
    endfunction

    // Ticks carry random payload bits; the block must ignore them.
    task automatic push_ticks(int n);
        item_t it;
        repeat (n)
        begin
            it = make_update(4'($urandom()), random_digits());
            it.command = CMD_TICK;
            pending_items.push_back(it);
        end
    endtask

    // Wait for every queued transaction to land, then finish any running
    // sequence so the block is idle before a register write.
    task automatic settle();
        wait (pending_items.size() == 0 && !item_valid);
        wait (pin_levels_due.size() == 0);
        if (write_pos != 0)
        begin
            push_ticks(sequence_len(seg_count) - (write_pos - 1));
            wait (pending_items.size() == 0 && !item_valid);
            wait (pin_levels_due.size() == 0);
        end
        // margin for the registered result to drain
        repeat (4) @(posedge clk);
    endtask

    // APB write of the brightness register, then read it back.
    task automatic set_brightness(logic [3:0] lvl);
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= BRIGHT_ADDR; pwdata <= {28'd0, lvl};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        bright_reg = lvl;
        @(negedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[3:0] !== lvl)
        begin
            $error("brightness_level readback: expected %0d, got %0d", lvl, prdata[3:0]);
            fail_count++;
        end
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0;
        settings_used++;
    endtask

    // One random phase: mostly complete update sequences with random content,
    // with idle ticks, zero-count updates and updates while busy as noise.
    task automatic random_phase();
        int effective;
        int cnt;
        int len;
        effective = 0;
        while (effective < PHASE_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
                push_ticks($urandom_range(1, 3));
            if ($urandom_range(0, 5) == 0)
                pending_items.push_back(make_update(4'd0, random_digits()));
            // small counts dominate, saturating counts now and then
            cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 15) : $urandom_range(1, 6);
            pending_items.push_back(make_update(4'(cnt), random_digits()));
            len = sequence_len(cnt > MAX_DIGITS ? MAX_DIGITS : cnt);
            effective += 1 + len;
            for (int i = 0; i < len; i++)
            begin
                push_ticks(1);
                if ($urandom_range(0, 39) == 0)
                    pending_items.push_back(make_update(4'($urandom()), random_digits()));
            end
        end
    endtask

    initial
    begin
        logic [3:0] levels [6];
        levels = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd9, 4'd0};
        levels[5] = 4'($urandom_range(2, 7));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part.
        set_brightness(4'd5);
        push_ticks(2);                                          // tick while idle
        pending_items.push_back(make_update(4'd0, '1));         // zero count
        push_ticks(1);
        pending_items.push_back(make_update(4'd1, 48'hA5_5A_00_FF_0F_F0));
        push_ticks(3);
        pending_items.push_back(make_update(4'd6, '1));         // update while busy
        push_ticks(sequence_len(1) - 3);
        // count saturates; walking ones show the bit order
        pending_items.push_back(make_update(4'd15, 48'h01_02_04_08_10_20));
        push_ticks(sequence_len(6));
        settle();

        // Random phases across brightness settings, the last one without idling.
        for (int p = 0; p < 6; p++)
        begin
            set_brightness(levels[p]);
            if (p == 5)
                calm = 1'b1;
            random_phase();
            settle();
        end

        repeat (8) @(posedge clk);
        if (pin_levels_due.size() != 0)
        begin
            $error("%0d expected results never arrived", pin_levels_due.size());
            fail_count++;
        end
        $display("covered %0d updates, %0d completed sequences, %0d results checked",
                 updates_started, sequences_done, results_checked);
        $display("brightness settings written: %0d, including off and out-of-range levels",
                 settings_used);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
